[sv/smalu_pkg.sv]
package smalu_pkg;

    localparam int WordBits = 16;
    localparam int MagBits  = WordBits - 1;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INC = 3'd4;
    localparam logic [2:0] OP_DEC = 3'd5;
    localparam logic [2:0] OP_CMP = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [2:0]          op;
        logic [WordBits-1:0] operand_a;
        logic [WordBits-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic [WordBits-1:0] result_word;
        logic [1:0]          status;
        logic                less;
        logic                equal;
        logic                greater;
    } out_item_t;

    // data that rides along a cell of the division chain
    typedef struct packed {
        logic              vld;
        logic [2:0]        op;
        logic              na;
        logic              nb;
        logic [MagBits-1:0] ma;
        logic [MagBits-1:0] mb;
        logic [MagBits-1:0] quo;
        logic [MagBits-1:0] rem;
    } lane_t;

endpackage

[sv/smalu_cell.sv]
// One restoring-division step: brings in one dividend bit, produces one quotient bit.
module smalu_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [3:0]         bit_idx,
    input  smalu_pkg::lane_t   din,
    output smalu_pkg::lane_t   dout
);
    smalu_pkg::lane_t lane_reg, lane_next;
    logic [smalu_pkg::MagBits:0] trial;

    always_comb
    begin
        lane_next = din;
        trial = {din.rem, din.ma[bit_idx]};
        if (trial >= {1'b0, din.mb})
        begin
            lane_next.rem = smalu_pkg::MagBits'(trial - {1'b0, din.mb});
            lane_next.quo[bit_idx] = 1'b1;
        end
        else
        begin
            lane_next.rem = trial[smalu_pkg::MagBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else if (adv)
            lane_reg <= lane_next;
    end

    assign dout = lane_reg;
endmodule

[sv/smalu_finish.sv]
// Final stage: add/sub/inc/dec/mul/compare from the carried operands, divide from the chain.
module smalu_finish (
    input  smalu_pkg::lane_t  lane,
    output smalu_pkg::out_item_t res
);
    localparam logic [smalu_pkg::MagBits-1:0] MagMax = '1;
    logic [smalu_pkg::MagBits:0]     sum, dif;
    logic [2*smalu_pkg::MagBits-1:0] prod;
    logic                            sb, sa_neg, ovf, neg;
    logic [smalu_pkg::MagBits-1:0]   mb_eff, mag;
    logic [smalu_pkg::MagBits:0]     magw;

    always_comb
    begin
        res = '0;
        ovf = 1'b0;
        mb_eff = lane.mb;
        sb = lane.nb;
        sa_neg = lane.na;
        neg = 1'b0;
        magw = '0;
        case (lane.op)
            smalu_pkg::OP_SUB: sb = (lane.mb != '0) ? !lane.nb : 1'b0;
            smalu_pkg::OP_INC:
            begin
                mb_eff = smalu_pkg::MagBits'(1);
                sb = 1'b0;
            end
            smalu_pkg::OP_DEC:
            begin
                mb_eff = smalu_pkg::MagBits'(1);
                sb = 1'b1;
            end
            default: ;
        endcase
        sum  = {1'b0, lane.ma} + {1'b0, mb_eff};
        dif  = {1'b0, lane.ma} - {1'b0, mb_eff};
        prod = lane.ma * lane.mb;
        case (lane.op)
            smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_INC, smalu_pkg::OP_DEC:
            begin
                if (sa_neg == sb)
                begin
                    magw = sum;
                    neg = sa_neg;
                    ovf = sum[smalu_pkg::MagBits];
                end
                else if (!dif[smalu_pkg::MagBits])
                begin
                    magw = dif;
                    neg = sa_neg;
                end
                else
                begin
                    magw = -dif;
                    neg = sb;
                end
            end
            smalu_pkg::OP_MUL:
            begin
                ovf = prod > {{smalu_pkg::MagBits{1'b0}}, MagMax};
                magw = {1'b0, prod[smalu_pkg::MagBits-1:0]};
                neg = lane.na != lane.nb;
            end
            smalu_pkg::OP_DIV:
            begin
                magw = {1'b0, lane.quo};
                neg = lane.na != lane.nb;
                if (lane.mb == '0)
                begin
                    res.status = smalu_pkg::ST_DIV0;
                    magw = '0;
                end
            end
            smalu_pkg::OP_CMP:
            begin
                if (lane.na != lane.nb)
                begin
                    res.less = lane.na;
                    res.greater = !lane.na;
                end
                else if (lane.ma == lane.mb)
                    res.equal = 1'b1;
                else
                begin
                    res.greater = (lane.ma > lane.mb) ^ lane.na;
                    res.less = !((lane.ma > lane.mb) ^ lane.na);
                end
            end
            default: ;
        endcase
        mag = magw[smalu_pkg::MagBits-1:0];
        if (ovf)
        begin
            res.status = smalu_pkg::ST_OVF;
            mag = '0;
        end
        res.result_word = {neg && (mag != '0), mag};
    end
endmodule

[sv/sign_magnitude_alu.sv]
// Sign-magnitude ALU, 16-bit words (bit 15 sign, bits 14..0 magnitude).
//
// Input channel: in_valid / in_stall / in_data carries an item of opcode plus two
// operands. Output channel: out_valid / out_stall / out_data returns one result
// item per input item, in order.
//
// The depth is set by the divide chain: 15 restoring-division cells, one
// quotient bit each, plus the output register. All opcodes travel the same
// chain, so order is kept.
// Throughput: one item per cycle while the receiver takes results.
//
// When the receiver stalls while a result is held, the whole chain freezes
// and in_stall rises; a held result never changes. Empty slots are not
// squeezed out: the chain moves as one, and a bubble inside it freezes too.
// The chain advances whenever the output slot is empty or being taken.
//
// Reset clears the division chain and the output valid bit; the output
// payload register keeps whatever it holds.
module sign_magnitude_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  smalu_pkg::in_item_t    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output smalu_pkg::out_item_t   out_data
);
    localparam int Cells = smalu_pkg::MagBits;

    smalu_pkg::lane_t     chain [Cells+1];
    smalu_pkg::out_item_t res_next, res_reg;
    logic                 vld_reg;
    logic                 adv;

    // advance when the output slot is free or being taken
    assign adv      = !vld_reg || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        chain[0].vld = in_valid;
        chain[0].op  = in_data.op;
        chain[0].ma  = in_data.operand_a[smalu_pkg::MagBits-1:0];
        chain[0].mb  = in_data.operand_b[smalu_pkg::MagBits-1:0];
        chain[0].na  = in_data.operand_a[smalu_pkg::MagBits] && (chain[0].ma != '0);
        chain[0].nb  = in_data.operand_b[smalu_pkg::MagBits] && (chain[0].mb != '0);
        chain[0].quo = '0;
        chain[0].rem = '0;
    end

    // quotient bits from the top down, one per cell
    for (genvar i = 0; i < Cells; i++)
    begin : g_cell
        smalu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .bit_idx (4'(Cells - 1 - i)),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    smalu_finish u_finish (
        .lane (chain[Cells]),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= chain[Cells].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = res_reg;

    // a held result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // error results carry a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != smalu_pkg::ST_OK) |-> out_data.result_word == '0)
        else $error("error result not zero");

    // never negative zero
    a_no_negz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.result_word != {1'b1, {smalu_pkg::MagBits{1'b0}}})
        else $error("negative zero result");

    // at most one compare flag
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({out_data.less, out_data.equal, out_data.greater}))
        else $error("compare flags not exclusive");
endmodule
